// ----- hdl/dpr_pkg.sv -----
// Shared constants, register indexes and payload types of the depth reprojection block.
package dpr_pkg;

   localparam int COORD_BITS = 16;
   localparam int DEPTH_BITS = 24;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ROT0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ZSIGN = 3'd6;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_ZERO_DEPTH = 3'd1;
   localparam logic [2:0] ST_ZERO_FOCAL = 3'd2;
   localparam logic [2:0] ST_BEHIND     = 3'd3;
   localparam logic [2:0] ST_SAT        = 3'd4;

   localparam int ROT_W   = 20;
   localparam int TRANS_W = 21;
   localparam int PT_W    = 43;
   localparam logic [PT_W-2:0] PT_LIM = '1;

   // (x << 16) - cx, signed, wide enough for the largest coordinate width
   localparam int SUB_W = 38;

   // divider numerator, divisor and rounded quotient widths, common to every dpr_div instance
   localparam int DIV_NW  = 62;
   localparam int DIV_DW  = 46;
   localparam int DIV_QW  = DIV_NW + 1;
   localparam int DIV_LAT = DIV_NW + 2;

   // back-projection ratio magnitude is split in two halves for the depth multiply
   localparam int Q1_H = 27;
   localparam int Q1_W = 2 * Q1_H;

   localparam logic signed [31:0] OUT_INVALID = -32'sd256;

   typedef struct packed {
      logic [COORD_BITS-1:0] cur_x;
      logic [COORD_BITS-1:0] cur_y;
      logic [DEPTH_BITS-1:0] depth;
   } req_type;

   typedef struct packed {
      logic signed [31:0] ref_x;
      logic signed [31:0] ref_y;
      logic               valid_res;
      logic [2:0]         status;
   } rsp_type;

endpackage

// ----- hdl/depth_pixel_reprojection.sv -----
// Top level: pinhole depth reprojection pipeline with its register file.
//
// Takes one pixel per clock: busy stays low and start alone transfers a pixel. Every pixel
// gives one result, strobed on rsp_strobe for one cycle; results leave in the order pixels
// came in. The datapath holds two pipelined dividers (pixel ratio by focal length, then point
// by depth), each 62 stages plus capture and rounding. The user must write registers through
// the csr port only while no pixel is in flight; the block itself does not enforce it.
module depth_pixel_reprojection (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  dpr_pkg::req_type                    req_data,
   output logic                                rsp_strobe,
   output dpr_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [dpr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dpr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int DB   = dpr_pkg::DEPTH_BITS;
   localparam int NW   = dpr_pkg::DIV_NW;
   localparam int DW   = dpr_pkg::DIV_DW;
   localparam int QW   = dpr_pkg::DIV_QW;
   localparam int LAT  = dpr_pkg::DIV_LAT;
   localparam int SW   = dpr_pkg::SUB_W;
   localparam int QH   = dpr_pkg::Q1_H;
   localparam int QF   = dpr_pkg::Q1_W;
   localparam int RW   = dpr_pkg::ROT_W;
   localparam int TW   = dpr_pkg::TRANS_W;
   localparam int PW   = dpr_pkg::PT_W;
   localparam int PRW  = QF + DB;
   localparam int LOW  = 22;
   localparam int WW   = 48;

   typedef struct packed {
      logic          vld;
      logic          zd;
      logic          zf;
      logic [1:0]    neg;
      logic [DB-1:0] z;
   } sb1_type;

   typedef struct packed {
      logic vld;
      logic zd;
      logic zf;
      logic sat;
   } sbp_type;

   typedef struct packed {
      logic       vld;
      logic       zd;
      logic       zf;
      logic       behind;
      logic       sat;
      logic [1:0] neg;
   } sb2_type;

   // ---------------- configuration registers ----------------
   logic [59:0]   rot_ff [0:2];
   logic [62:0]   trans_ff;
   logic [63:0]   focal_ff;
   logic [63:0]   pp_ff;
   logic          zneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= 60'd1 << 18;
         rot_ff[1] <= 60'd1 << 38;
         rot_ff[2] <= 60'd1 << 58;
         trans_ff  <= '0;
         focal_ff  <= '0;
         pp_ff     <= '0;
         zneg_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            dpr_pkg::CSR_ROT0:  rot_ff[0] <= csr_wdata[59:0];
            dpr_pkg::CSR_ROT1:  rot_ff[1] <= csr_wdata[59:0];
            dpr_pkg::CSR_ROT2:  rot_ff[2] <= csr_wdata[59:0];
            dpr_pkg::CSR_TRANS: trans_ff  <= csr_wdata[62:0];
            dpr_pkg::CSR_FOCAL: focal_ff  <= csr_wdata;
            dpr_pkg::CSR_PP:    pp_ff     <= csr_wdata;
            dpr_pkg::CSR_ZSIGN: zneg_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // decoded configuration, to be kept static by the user while pixels are in flight (not enforced here)
   logic [31:0]             f_w   [0:1];
   logic [31:0]             fm_w  [0:1];
   logic [31:0]             c_w   [0:1];
   logic signed [24:0]      cr_w  [0:1];
   logic signed [RW-1:0]    rot_w [0:2][0:2];
   logic signed [TW-1:0]    t_w   [0:2];
   logic [31:0]             cm_w;
   logic [32:0]             csum_w;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         f_w[a]  = focal_ff[32*a +: 32];
         c_w[a]  = pp_ff[32*a +: 32];
         fm_w[a] = f_w[a][31] ? (~f_w[a] + 32'd1) : f_w[a];
      end
      for (int i = 0; i < 3; i++) begin
         t_w[i] = $signed(trans_ff[TW*i +: TW]);
         for (int k = 0; k < 3; k++) begin
            rot_w[i][k] = $signed(rot_ff[i][RW*k +: RW]);
         end
      end
      cm_w   = '0;
      csum_w = '0;
      for (int a = 0; a < 2; a++) begin
         cm_w   = c_w[a][31] ? (~c_w[a] + 32'd1) : c_w[a];
         csum_w = {1'b0, cm_w} + 33'd128;
         cr_w[a] = c_w[a][31] ? -$signed({1'b0, csum_w[31:8]})
                              : $signed({1'b0, csum_w[31:8]});
      end
   end

   assign busy = 1'b0;

   // ---------------- stage A: capture ----------------
   logic             a_vld_ff;
   dpr_pkg::req_type a_req_ff;

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else       a_vld_ff <= start;
      a_req_ff <= req_data;
   end

   // ---------------- stage B: ratio numerators ----------------
   logic [dpr_pkg::COORD_BITS-1:0] crd_w [0:1];
   logic signed [SW-1:0]           sub_in [0:1];
   logic [SW-1:0]                  smag_in [0:1];
   logic [NW-1:0]                  b_num_ff [0:1];
   logic [DW-1:0]                  b_den_ff [0:1];
   sb1_type                        b_sb_ff;

   assign crd_w[0] = a_req_ff.cur_x;
   assign crd_w[1] = a_req_ff.cur_y;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         sub_in[a] = $signed({{(SW-dpr_pkg::COORD_BITS-16){1'b0}}, crd_w[a], 16'h0})
                   - $signed({{(SW-32){c_w[a][31]}}, c_w[a]});
         smag_in[a] = sub_in[a][SW-1] ? $unsigned(-sub_in[a]) : $unsigned(sub_in[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_sb_ff <= '0;
      end else begin
         b_sb_ff.vld <= a_vld_ff;
         b_sb_ff.zd  <= a_req_ff.depth == '0;
         b_sb_ff.zf  <= (f_w[0] == '0) || (f_w[1] == '0);
         b_sb_ff.neg <= {sub_in[1][SW-1] ^ f_w[1][31], sub_in[0][SW-1] ^ f_w[0][31]};
         b_sb_ff.z   <= a_req_ff.depth;
      end
      for (int a = 0; a < 2; a++) begin
         b_num_ff[a] <= {{(NW-SW-16){1'b0}}, smag_in[a], 16'h0};
         b_den_ff[a] <= {{(DW-32){1'b0}}, fm_w[a]};
      end
   end

   // ---------------- divider 1: ratio = numerator / focal ----------------
   logic [QW-1:0] q1_w [0:1];
   sb1_type       sb1_ff [0:LAT-1];

   for (genvar a = 0; a < 2; a++) begin : g_div1
      dpr_div u_div (
         .clock (clock),
         .num   (b_num_ff[a]),
         .den   (b_den_ff[a]),
         .quot  (q1_w[a])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT; j++) sb1_ff[j] <= '0;
      end else begin
         sb1_ff[0] <= b_sb_ff;
         for (int j = 1; j < LAT; j++) sb1_ff[j] <= sb1_ff[j-1];
      end
   end

   // ---------------- stage C: ratio times depth, partial products ----------------
   logic [QH+DB-1:0] c_plo_ff [0:1];
   logic [QH+DB-1:0] c_phi_ff [0:1];
   logic [1:0]       c_big_ff;
   sb1_type          c_sb_ff;

   always_ff @(posedge clock) begin
      if (reset) c_sb_ff <= '0;
      else       c_sb_ff <= sb1_ff[LAT-1];
      for (int a = 0; a < 2; a++) begin
         c_plo_ff[a] <= q1_w[a][QH-1:0] * sb1_ff[LAT-1].z;
         c_phi_ff[a] <= q1_w[a][QF-1:QH] * sb1_ff[LAT-1].z;
         c_big_ff[a] <= |q1_w[a][QW-1:QF];
      end
   end

   // ---------------- stage D: combine, round, clamp to the point range ----------------
   logic [PRW-1:0]       prod_in [0:1];
   logic [PRW-1:0]       prnd_in [0:1];
   logic [1:0]           psat_in;
   logic [PW-2:0]        pmag_in [0:1];
   logic signed [PW-1:0] d_p_ff [0:1];
   logic signed [DB:0]   d_pz_ff;
   sbp_type              d_sb_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         prod_in[a] = {c_phi_ff[a], {QH{1'b0}}} + PRW'(c_plo_ff[a]);
         prnd_in[a] = prod_in[a] + PRW'(32768);
         psat_in[a] = c_big_ff[a] || (prod_in[a] > PRW'({dpr_pkg::PT_LIM, 16'h0}));
         pmag_in[a] = psat_in[a] ? dpr_pkg::PT_LIM : prnd_in[a][PW+14:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_sb_ff <= '0;
      end else begin
         d_sb_ff.vld <= c_sb_ff.vld;
         d_sb_ff.zd  <= c_sb_ff.zd;
         d_sb_ff.zf  <= c_sb_ff.zf;
         d_sb_ff.sat <= |psat_in;
      end
      for (int a = 0; a < 2; a++) begin
         d_p_ff[a] <= c_sb_ff.neg[a] ? -$signed({1'b0, pmag_in[a]})
                                      : $signed({1'b0, pmag_in[a]});
      end
      d_pz_ff <= zneg_ff ? -$signed({1'b0, c_sb_ff.z}) : $signed({1'b0, c_sb_ff.z});
   end

   // ---------------- stage E: rotation partial products ----------------
   logic signed [RW+LOW:0]      e_lo_ff [0:2][0:1];
   logic signed [RW+PW-LOW-1:0] e_hi_ff [0:2][0:1];
   logic signed [RW+DB:0]       e_z_ff  [0:2];
   sbp_type                     e_sb_ff;

   always_ff @(posedge clock) begin
      if (reset) e_sb_ff <= '0;
      else       e_sb_ff <= d_sb_ff;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 2; k++) begin
            e_lo_ff[i][k] <= rot_w[i][k] * $signed({1'b0, d_p_ff[k][LOW-1:0]});
            e_hi_ff[i][k] <= rot_w[i][k] * $signed(d_p_ff[k][PW-1:LOW]);
         end
         e_z_ff[i] <= rot_w[i][2] * d_pz_ff;
      end
   end

   // ---------------- stage F: row sums ----------------
   logic signed [63:0] f_s_ff [0:2];
   sbp_type            f_sb_ff;

   always_ff @(posedge clock) begin
      if (reset) f_sb_ff <= '0;
      else       f_sb_ff <= e_sb_ff;
      for (int i = 0; i < 3; i++) begin
         f_s_ff[i] <= (64'(e_hi_ff[i][0]) <<< LOW) + 64'(e_lo_ff[i][0])
                    + (64'(e_hi_ff[i][1]) <<< LOW) + 64'(e_lo_ff[i][1])
                    + 64'(e_z_ff[i]);
      end
   end

   // ---------------- stage G: drop the rotation fraction ----------------
   logic [63:0]        smg_in [0:2];
   logic [63:0]        srd_in [0:2];
   logic signed [46:0] g_r_ff [0:2];
   sbp_type            g_sb_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         smg_in[i] = f_s_ff[i][63] ? $unsigned(-f_s_ff[i]) : $unsigned(f_s_ff[i]);
         srd_in[i] = smg_in[i] + 64'h2_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) g_sb_ff <= '0;
      else       g_sb_ff <= f_sb_ff;
      for (int i = 0; i < 3; i++) begin
         g_r_ff[i] <= f_s_ff[i][63] ? -$signed({1'b0, srd_in[i][63:18]})
                                     : $signed({1'b0, srd_in[i][63:18]});
      end
   end

   // ---------------- stage H: translation ----------------
   logic signed [WW-1:0] h_w_ff [0:2];
   sbp_type              h_sb_ff;

   always_ff @(posedge clock) begin
      if (reset) h_sb_ff <= '0;
      else       h_sb_ff <= g_sb_ff;
      for (int i = 0; i < 3; i++) begin
         h_w_ff[i] <= WW'(g_r_ff[i]) + (WW'(t_w[i]) <<< 4);
      end
   end

   // ---------------- stage I: depth test, divider operands ----------------
   logic [WW-1:0] wmag_in [0:2];
   logic          behind_in;
   logic [NW-1:0] i_num_ff [0:1];
   logic [DW-1:0] i_den_ff;
   sb2_type       i_sb_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wmag_in[i] = h_w_ff[i][WW-1] ? $unsigned(-h_w_ff[i]) : $unsigned(h_w_ff[i]);
      end
      behind_in = zneg_ff ? !h_w_ff[2][WW-1]
                          : (h_w_ff[2][WW-1] || (h_w_ff[2] == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_sb_ff <= '0;
      end else begin
         i_sb_ff.vld    <= h_sb_ff.vld;
         i_sb_ff.zd     <= h_sb_ff.zd;
         i_sb_ff.zf     <= h_sb_ff.zf;
         i_sb_ff.sat    <= h_sb_ff.sat;
         i_sb_ff.behind <= behind_in;
         i_sb_ff.neg    <= {f_w[1][31] ^ h_w_ff[1][WW-1], f_w[0][31] ^ h_w_ff[0][WW-1]};
      end
      for (int a = 0; a < 2; a++) begin
         i_num_ff[a] <= {wmag_in[a][DW-1:0], 16'h0};
      end
      i_den_ff <= wmag_in[2][DW-1:0];
   end

   // ---------------- divider 2: point / |Z| ----------------
   logic [QW-1:0] q2_w [0:1];
   sb2_type       sb2_ff [0:LAT-1];

   for (genvar a = 0; a < 2; a++) begin : g_div2
      dpr_div u_div (
         .clock (clock),
         .num   (i_num_ff[a]),
         .den   (i_den_ff),
         .quot  (q2_w[a])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT; j++) sb2_ff[j] <= '0;
      end else begin
         sb2_ff[0] <= i_sb_ff;
         for (int j = 1; j < LAT; j++) sb2_ff[j] <= sb2_ff[j-1];
      end
   end

   // ---------------- stage J: focal times ratio, partial products ----------------
   logic [63:0] j_plo_ff [0:1];
   logic [62:0] j_phi_ff [0:1];
   sb2_type     j_sb_ff;

   always_ff @(posedge clock) begin
      if (reset) j_sb_ff <= '0;
      else       j_sb_ff <= sb2_ff[LAT-1];
      for (int a = 0; a < 2; a++) begin
         j_plo_ff[a] <= fm_w[a] * q2_w[a][31:0];
         j_phi_ff[a] <= fm_w[a] * q2_w[a][QW-1:32];
      end
   end

   // ---------------- stage K: combine and clamp at 2^56 ----------------
   logic [94:0] tot_in [0:1];
   logic [1:0]  ksat_in;
   logic [56:0] k_p_ff [0:1];
   sb2_type     k_sb_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         tot_in[a]  = {j_phi_ff[a], 32'h0} + 95'(j_plo_ff[a]);
         ksat_in[a] = tot_in[a] > (95'd1 << 56);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_sb_ff <= '0;
      end else begin
         k_sb_ff     <= j_sb_ff;
         k_sb_ff.sat <= j_sb_ff.sat | (|ksat_in);
      end
      for (int a = 0; a < 2; a++) begin
         k_p_ff[a] <= ksat_in[a] ? (57'd1 << 56) : tot_in[a][56:0];
      end
   end

   // ---------------- stage L: drop the fraction, apply sign ----------------
   logic [56:0]        lrd_in [0:1];
   logic signed [33:0] l_m_ff [0:1];
   sb2_type            l_sb_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         lrd_in[a] = k_p_ff[a] + 57'h80_0000;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) l_sb_ff <= '0;
      else       l_sb_ff <= k_sb_ff;
      for (int a = 0; a < 2; a++) begin
         l_m_ff[a] <= k_sb_ff.neg[a] ? -$signed({1'b0, lrd_in[a][56:24]})
                                      : $signed({1'b0, lrd_in[a][56:24]});
      end
   end

   // ---------------- stage M: add principal point, saturate, result ----------------
   logic signed [34:0] v_in   [0:1];
   logic [1:0]         vsat_in;
   logic signed [31:0] vclp_in [0:1];
   logic [2:0]         st_in;
   logic               rsp_vld_ff;
   dpr_pkg::rsp_type   rsp_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         v_in[a]    = 35'(l_m_ff[a]) + 35'(cr_w[a]);
         vsat_in[a] = (v_in[a][34:31] != 4'h0) && (v_in[a][34:31] != 4'hF);
         vclp_in[a] = vsat_in[a] ? (v_in[a][34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                 : v_in[a][31:0];
      end
      if (l_sb_ff.zd)                   st_in = dpr_pkg::ST_ZERO_DEPTH;
      else if (l_sb_ff.zf)              st_in = dpr_pkg::ST_ZERO_FOCAL;
      else if (l_sb_ff.behind)          st_in = dpr_pkg::ST_BEHIND;
      else if (l_sb_ff.sat || |vsat_in) st_in = dpr_pkg::ST_SAT;
      else                              st_in = dpr_pkg::ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else       rsp_vld_ff <= l_sb_ff.vld;
      rsp_ff.status    <= st_in;
      rsp_ff.valid_res <= st_in == dpr_pkg::ST_OK;
      // pixels with zero depth, zero focal length or behind the camera report -1.0 instead of coordinates
      if (l_sb_ff.zd || l_sb_ff.zf || l_sb_ff.behind) begin
         rsp_ff.ref_x <= dpr_pkg::OUT_INVALID;
         rsp_ff.ref_y <= dpr_pkg::OUT_INVALID;
      end else begin
         rsp_ff.ref_x <= vclp_in[0];
         rsp_ff.ref_y <= vclp_in[1];
      end
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- hdl/dpr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
module dpr_div (
   input  logic                       clock,
   input  logic [dpr_pkg::DIV_NW-1:0] num,
   input  logic [dpr_pkg::DIV_DW-1:0] den,
   output logic [dpr_pkg::DIV_QW-1:0] quot
);

   localparam int NW = dpr_pkg::DIV_NW;
   localparam int DW = dpr_pkg::DIV_DW;
   localparam int QW = dpr_pkg::DIV_QW;

   logic [NW-1:0] num_ff [0:NW-1];
   logic [DW-1:0] den_ff [0:NW];
   logic [DW-1:0] rem_ff [1:NW];
   logic [NW-1:0] quo_ff [1:NW];
   logic [QW-1:0] quot_ff;
   logic [DW-1:0] half_in;
   logic          up_in;

   always_ff @(posedge clock) begin
      num_ff[0] <= num;
      den_ff[0] <= den;
   end

   for (genvar k = 0; k < NW; k++) begin : g_step
      logic [DW-1:0] rem_cur;
      logic [NW-1:0] quo_cur;
      logic [DW:0]   trial_in;
      logic [DW:0]   diff_in;
      logic          ge_in;

      if (k == 0) begin : g_first
         assign rem_cur = '0;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k];
         assign quo_cur = quo_ff[k];
      end

      always_comb begin
         trial_in = {rem_cur, num_ff[k][NW-1]};
         diff_in  = trial_in - {1'b0, den_ff[k]};
         ge_in    = trial_in >= {1'b0, den_ff[k]};
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge_in ? diff_in[DW-1:0] : trial_in[DW-1:0];
         quo_ff[k+1] <= {quo_cur[NW-2:0], ge_in};
         den_ff[k+1] <= den_ff[k];
      end

      if (k < NW - 1) begin : g_shift
         always_ff @(posedge clock) begin
            num_ff[k+1] <= num_ff[k] << 1;
         end
      end
   end

   // round up when the remainder is at least half the divisor
   always_comb begin
      half_in = den_ff[NW] - rem_ff[NW];
      up_in   = rem_ff[NW] >= half_in;
   end

   always_ff @(posedge clock) begin
      quot_ff <= {1'b0, quo_ff[NW]} + QW'(up_in);
   end

   assign quot = quot_ff;

endmodule
